FILE: sv/dsef_pkg.sv
// ----------------------------------------------------------------------------
// dsef_pkg
// Shared types and constants for the dual slew envelope follower.
// ----------------------------------------------------------------------------
package dsef_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int CV_LIMIT    = 30720;
   localparam int TRIG_LEVEL  = 4096;
   localparam int WARN_LEVEL  = 20460;
   localparam int FALL_SNAP   = 2 << FRAC_BITS;
   localparam int ROUND_SHIFT = 30;

   localparam logic [29:0]        RISE_STEP_RESET = 30'd26090000;
   localparam logic [29:0]        FALL_STEP_RESET = 30'd4129000;
   localparam logic signed [16:0] GAIN_RESET      = 17'sd16384;
   localparam logic signed [15:0] OFFSET_RESET    = 16'sd0;

   typedef enum logic [2:0] {
      REG_RISE_STEP_A = 3'd0,
      REG_FALL_STEP_A = 3'd1,
      REG_GAIN_A      = 3'd2,
      REG_OFFSET_A    = 3'd3,
      REG_RISE_STEP_B = 3'd4,
      REG_FALL_STEP_B = 3'd5,
      REG_GAIN_B      = 3'd6,
      REG_OFFSET_B    = 3'd7
   } dsef_reg_type;

   typedef struct packed {
      logic [29:0]        rise_step;
      logic [29:0]        fall_step;
      logic signed [16:0] gain;
      logic signed [15:0] offset;
   } dsef_cfg_type;

   // stage load strobes, one per pipeline register
   typedef struct packed {
      logic ld_in;
      logic ld_slew;
      logic ld_mult;
      logic ld_out;
   } dsef_ctl_type;

endpackage

FILE: sv/dsef_channel.sv
// ----------------------------------------------------------------------------
// dsef_channel
// One channel: slew-limited follower, gain multiply, round, offset, clamp.
// ----------------------------------------------------------------------------
module dsef_channel import dsef_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dsef_ctl_type       ctl,
   input  dsef_cfg_type       cfg,
   input  logic signed [15:0] sample,
   input  logic               connected,
   output logic signed [15:0] cv,
   output logic               trig,
   output logic               warn,
   output logic signed [15:0] level
);

   // input stage
   logic signed [15:0] sample_ff;
   logic               conn1_ff;

   // slew stage
   logic signed [32:0] follower_ff, follower_in;
   logic signed [32:0] fol2_ff;
   logic               conn2_ff, warn2_ff;

   // multiply stage
   logic signed [49:0] prod_ff, prod_in;
   logic               conn3_ff, warn3_ff;
   logic signed [15:0] level3_ff;

   // output stage
   logic signed [15:0] held_cv_ff;
   logic               held_trig_ff;
   logic signed [15:0] cv_ff;
   logic               trig_ff, warn_ff;
   logic signed [15:0] level_ff;

   logic signed [34:0] target, fol_ext, diff, rise_sum, fall_dif, nf;
   logic signed [50:0] biased;
   logic signed [20:0] rnd;
   logic signed [21:0] sum;
   logic signed [15:0] cv_new;
   logic               trig_new;

   always_comb begin
      target   = {{3{sample_ff[15]}}, sample_ff, 16'h0000};
      fol_ext  = {{2{follower_ff[32]}}, follower_ff};
      diff     = target - fol_ext;
      rise_sum = fol_ext + $signed({5'b0, cfg.rise_step});
      fall_dif = fol_ext - $signed({5'b0, cfg.fall_step});
      if (diff > 35'sd0) begin
         nf = (rise_sum >= target) ? target : rise_sum;
      end else if (diff < 35'sd0) begin
         nf = ((fall_dif - target) <= 35'(FALL_SNAP)) ? target : fall_dif;
      end else begin
         nf = target;
      end
      follower_in = nf[32:0];
   end

   assign prod_in = 50'(fol2_ff) * 50'(cfg.gain);

   always_comb begin
      biased = {prod_ff[49], prod_ff} + (51'sd1 <<< (ROUND_SHIFT - 1));
      rnd    = biased[50:ROUND_SHIFT];
      sum    = {rnd[20], rnd} + {{6{cfg.offset[15]}}, cfg.offset};
      if (sum > 22'(CV_LIMIT)) begin
         cv_new = 16'(CV_LIMIT);
      end else if (sum < -22'(CV_LIMIT)) begin
         cv_new = -16'(CV_LIMIT);
      end else begin
         cv_new = sum[15:0];
      end
      trig_new = (cv_new >= 16'(TRIG_LEVEL));
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_in) begin
         sample_ff <= sample;
         conn1_ff  <= connected;
      end
      if (ctl.ld_slew) begin
         fol2_ff  <= follower_in;
         conn2_ff <= conn1_ff;
         warn2_ff <= (sample_ff >= 16'(WARN_LEVEL));
      end
      if (ctl.ld_mult) begin
         prod_ff   <= prod_in;
         conn3_ff  <= conn2_ff;
         warn3_ff  <= warn2_ff;
         level3_ff <= fol2_ff[31:16];
      end
      if (ctl.ld_out) begin
         cv_ff    <= conn3_ff ? cv_new : held_cv_ff;
         trig_ff  <= conn3_ff ? trig_new : held_trig_ff;
         warn_ff  <= warn3_ff;
         level_ff <= level3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         follower_ff  <= '0;
         held_cv_ff   <= '0;
         held_trig_ff <= 1'b0;
      end else begin
         if (ctl.ld_slew) begin
            follower_ff <= follower_in;
         end
         if (ctl.ld_out && conn3_ff) begin
            held_cv_ff   <= cv_new;
            held_trig_ff <= trig_new;
         end
      end
   end

   assign cv    = cv_ff;
   assign trig  = trig_ff;
   assign warn  = warn_ff;
   assign level = level_ff;

endmodule

FILE: sv/dual_slew_envelope_follower_unit.sv
// ----------------------------------------------------------------------------
// dual_slew_envelope_follower_unit
// Two-channel linear slew limiter with gain, offset, clamp and level flags.
//
//   channel  dir  fields
//   req_*    in   tdata: sample_a, sample_b; tuser: connected_a, connected_b
//   rsp_*    out  tdata: cv_a, cv_b, trig_a, trig_b, warn_a, warn_b,
//                        level_a, level_b
//   csr_*    in   APB register port, eight registers at 4*i
//
// One item per cycle sustained while rsp_tready holds; four register stages
// (input, slew, multiply, output), each passed in turn before rsp_tvalid rises.
// The follower update is the only loop and closes within the slew stage.
// Each stage fills when empty, so bubbles close up while rsp is stalled.
// Synchronous reset clears followers, held cv/trig, valids; presets registers.
// ----------------------------------------------------------------------------
module dual_slew_envelope_follower_unit import dsef_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_a, [31:16] sample_b
   input  logic [1:0]  req_tuser,   // [0] connected_a, [1] connected_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] cv_a, [31:16] cv_b, [32] trig_a,
                                    // [33] trig_b, [34] warn_a, [35] warn_b,
                                    // [51:36] level_a, [67:52] level_b, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dsef_cfg_type cfg_a_ff, cfg_b_ff;
   dsef_ctl_type ctl;
   dsef_reg_type reg_sel;
   logic         csr_wr;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic v1_in, v2_in, v3_in, vo_in;
   logic rdy_o, rdy3, rdy2, rdy1;
   logic acc, mv1, mv2, mv3;

   logic signed [15:0] cv_a, cv_b, level_a, level_b;
   logic               trig_a, trig_b, warn_a, warn_b;

   // ---- register port ----
   assign csr_pready = 1'b1;
   assign reg_sel    = dsef_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_a_ff <= '{RISE_STEP_RESET, FALL_STEP_RESET, GAIN_RESET, OFFSET_RESET};
         cfg_b_ff <= '{RISE_STEP_RESET, FALL_STEP_RESET, GAIN_RESET, OFFSET_RESET};
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_RISE_STEP_A: cfg_a_ff.rise_step <= csr_pwdata[29:0];
            REG_FALL_STEP_A: cfg_a_ff.fall_step <= csr_pwdata[29:0];
            REG_GAIN_A:      cfg_a_ff.gain      <= csr_pwdata[16:0];
            REG_OFFSET_A:    cfg_a_ff.offset    <= csr_pwdata[15:0];
            REG_RISE_STEP_B: cfg_b_ff.rise_step <= csr_pwdata[29:0];
            REG_FALL_STEP_B: cfg_b_ff.fall_step <= csr_pwdata[29:0];
            REG_GAIN_B:      cfg_b_ff.gain      <= csr_pwdata[16:0];
            REG_OFFSET_B:    cfg_b_ff.offset    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RISE_STEP_A: csr_prdata = {2'b0, cfg_a_ff.rise_step};
         REG_FALL_STEP_A: csr_prdata = {2'b0, cfg_a_ff.fall_step};
         REG_GAIN_A:      csr_prdata = {{15{cfg_a_ff.gain[16]}}, cfg_a_ff.gain};
         REG_OFFSET_A:    csr_prdata = {{16{cfg_a_ff.offset[15]}}, cfg_a_ff.offset};
         REG_RISE_STEP_B: csr_prdata = {2'b0, cfg_b_ff.rise_step};
         REG_FALL_STEP_B: csr_prdata = {2'b0, cfg_b_ff.fall_step};
         REG_GAIN_B:      csr_prdata = {{15{cfg_b_ff.gain[16]}}, cfg_b_ff.gain};
         REG_OFFSET_B:    csr_prdata = {{16{cfg_b_ff.offset[15]}}, cfg_b_ff.offset};
         default:         csr_prdata = '0;
      endcase
   end

   // ---- pipeline flow control ----
   always_comb begin
      rdy_o = !vo_ff || rsp_tready;
      mv3   = v3_ff && rdy_o;
      rdy3  = !v3_ff || rdy_o;
      mv2   = v2_ff && rdy3;
      rdy2  = !v2_ff || rdy3;
      mv1   = v1_ff && rdy2;
      rdy1  = !v1_ff || rdy2;
      acc   = req_tvalid && rdy1;

      v1_in = acc || (v1_ff && !mv1);
      v2_in = mv1 || (v2_ff && !mv2);
      v3_in = mv2 || (v3_ff && !mv3);
      vo_in = mv3 || (vo_ff && !rsp_tready);

      ctl.ld_in   = acc;
      ctl.ld_slew = mv1;
      ctl.ld_mult = mv2;
      ctl.ld_out  = mv3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   assign req_tready = rdy1;
   assign rsp_tvalid = vo_ff;

   dsef_channel u_chan_a (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_a_ff),
      .sample    (req_tdata[15:0]),
      .connected (req_tuser[0]),
      .cv        (cv_a),
      .trig      (trig_a),
      .warn      (warn_a),
      .level     (level_a)
   );

   dsef_channel u_chan_b (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_b_ff),
      .sample    (req_tdata[31:16]),
      .connected (req_tuser[1]),
      .cv        (cv_b),
      .trig      (trig_b),
      .warn      (warn_b),
      .level     (level_b)
   );

   assign rsp_tdata = {4'h0, level_b, level_a, warn_b, warn_a, trig_b, trig_a, cv_b, cv_a};

   // ---- assertions ----
   a_out_from_stage3: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v3_ff))
      else $error("result appeared without an item in the multiply stage");

   a_cv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cv_a <= 16'sd30720 && cv_a >= -16'sd30720 &&
                      cv_b <= 16'sd30720 && cv_b >= -16'sd30720))
      else $error("cv outside clamp range");

   a_trig_matches_cv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (trig_a == (cv_a >= 16'sd4096) && trig_b == (cv_b >= 16'sd4096)))
      else $error("trig disagrees with cv");

   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && vo_ff))
      else $error("input stalled while a stage is empty");

endmodule

FILE: verif/dsef_checker.sv
// ----------------------------------------------------------------------------
// dsef_checker
// Watches the request, result and register channels of the dual slew
// envelope follower. It keeps its own follower state and register copies,
// predicts each result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module dsef_checker import dsef_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_a, [31:16] sample_b
   input  logic [1:0]  req_tuser,   // [0] connected_a, [1] connected_b
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // cv_a, cv_b, trig_a, trig_b, warn_a, warn_b,
                                    // level_a, level_b, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // laid out as rsp_tdata[67:0]
   typedef struct packed {
      logic signed [15:0] level_b;
      logic signed [15:0] level_a;
      logic               warn_b;
      logic               warn_a;
      logic               trig_b;
      logic               trig_a;
      logic signed [15:0] cv_b;
      logic signed [15:0] cv_a;
   } envelope_result_type;

   longint rise_step [2];
   longint fall_step [2];
   longint gain      [2];
   longint offset    [2];
   longint follower  [2];
   longint held_cv   [2];
   bit     held_trig [2];

   envelope_result_type envelope_q [$];

   function automatic envelope_result_type follow_item(logic [31:0] data, logic [1:0] conn);
      envelope_result_type r;
      longint             s, target, f, v;
      logic signed [15:0] cv  [2];
      logic signed [15:0] lvl [2];
      bit                 trg [2];
      bit                 wrn [2];
      for (int c = 0; c < 2; c++) begin
         s      = longint'(c ? $signed(data[31:16]) : $signed(data[15:0]));
         target = s * 65536;
         f      = follower[c];
         if (target > f) begin
            f = f + rise_step[c];
            if (!(target - f > 0))
               f = target;
         end else if (target < f) begin
            f = f - fall_step[c];
            if (target - f >= -FALL_SNAP)
               f = target;
         end else begin
            f = target;
         end
         follower[c] = f;
         if (conn[c]) begin
            v = ((f * gain[c] + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT)
                + offset[c];
            if (v > CV_LIMIT)
               v = CV_LIMIT;
            if (v < -CV_LIMIT)
               v = -CV_LIMIT;
            held_cv[c]   = v;
            held_trig[c] = (v >= TRIG_LEVEL);
         end
         cv[c]  = 16'(held_cv[c]);
         trg[c] = held_trig[c];
         wrn[c] = (s >= WARN_LEVEL);
         lvl[c] = 16'(f >>> FRAC_BITS);
      end
      r.cv_a    = cv[0];
      r.cv_b    = cv[1];
      r.trig_a  = trg[0];
      r.trig_b  = trg[1];
      r.warn_a  = wrn[0];
      r.warn_b  = wrn[1];
      r.level_a = lvl[0];
      r.level_b = lvl[1];
      return r;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      envelope_result_type exp_r;
      envelope_result_type act_r;
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            rise_step[c] = longint'(RISE_STEP_RESET);
            fall_step[c] = longint'(FALL_STEP_RESET);
            gain[c]      = longint'(GAIN_RESET);
            offset[c]    = longint'(OFFSET_RESET);
            follower[c]  = 0;
            held_cv[c]   = 0;
            held_trig[c] = 1'b0;
         end
         envelope_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (dsef_reg_type'(csr_paddr[4:2]))
               REG_RISE_STEP_A: rise_step[0] = longint'(csr_pwdata[29:0]);
               REG_FALL_STEP_A: fall_step[0] = longint'(csr_pwdata[29:0]);
               REG_GAIN_A:      gain[0]      = longint'($signed(csr_pwdata[16:0]));
               REG_OFFSET_A:    offset[0]    = longint'($signed(csr_pwdata[15:0]));
               REG_RISE_STEP_B: rise_step[1] = longint'(csr_pwdata[29:0]);
               REG_FALL_STEP_B: fall_step[1] = longint'(csr_pwdata[29:0]);
               REG_GAIN_B:      gain[1]      = longint'($signed(csr_pwdata[16:0]));
               REG_OFFSET_B:    offset[1]    = longint'($signed(csr_pwdata[15:0]));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            envelope_q.push_back(follow_item(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (envelope_q.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               exp_r = envelope_q.pop_front();
               act_r = rsp_tdata[67:0];
               check_field("cv_a",    exp_r.cv_a,    act_r.cv_a);
               check_field("cv_b",    exp_r.cv_b,    act_r.cv_b);
               check_field("trig_a",  exp_r.trig_a,  act_r.trig_a);
               check_field("trig_b",  exp_r.trig_b,  act_r.trig_b);
               check_field("warn_a",  exp_r.warn_a,  act_r.warn_a);
               check_field("warn_b",  exp_r.warn_b,  act_r.warn_b);
               check_field("level_a", exp_r.level_a, act_r.level_a);
               check_field("level_b", exp_r.level_b, act_r.level_b);
               check_field("pad",     0,             rsp_tdata[71:68]);
            end
         end
      end
      pending = envelope_q.size();
   end

endmodule

FILE: verif/tb_dual_slew_envelope_follower_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_slew_envelope_follower_unit
// Drives sample items and register writes into the dual slew envelope
// follower under random stalls on both channels, across several register
// settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dual_slew_envelope_follower_unit import dsef_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT    = 14;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [15:0] sample_a, [31:16] sample_b
   logic [1:0]  req_tuser   = '0;   // [0] connected_a, [1] connected_b
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [71:0] rsp_tdata;          // cv_a, cv_b, trig_a, trig_b, warn_a, warn_b,
                                    // level_a, level_b, zero pad
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int                 fail_count;
   int                 pending;
   int                 cycles = 0;
   bit                 quiet = 1'b0;
   bit                 hold_request = 1'b0;
   bit                 hold_taken = 1'b0;
   logic signed [15:0] seq_a = '0;
   logic signed [15:0] seq_b = '0;

   dual_slew_envelope_follower_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dsef_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random backpressure, one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic send_item(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic [1:0] conn);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= conn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input dsef_reg_type r, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_channel(input int c, input logic [31:0] rise, input logic [31:0] fall,
                              input logic [31:0] gain, input logic [31:0] offset);
      csr_write(c ? REG_RISE_STEP_B : REG_RISE_STEP_A, rise);
      csr_write(c ? REG_FALL_STEP_B : REG_FALL_STEP_A, fall);
      csr_write(c ? REG_GAIN_B : REG_GAIN_A, gain);
      csr_write(c ? REG_OFFSET_B : REG_OFFSET_A, offset);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly held levels so followers settle and snap, with jitter and jumps
   function automatic logic signed [15:0] next_sample(input logic signed [15:0] cur);
      int r, v;
      r = $urandom_range(0, 99);
      if (r < 78)
         v = cur;
      else if (r < 86)
         v = cur + int'($urandom_range(0, 6)) - 3;
      else if (r < 93)
         v = int'($urandom_range(0, 65535)) - 32768;
      else if (r < 96)
         v = WARN_LEVEL - 3 + int'($urandom_range(0, 6));
      else
         v = $urandom_range(0, 1) ? 32767 : -32768;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[15:0];
   endfunction

   task automatic run_random(input int n);
      logic [1:0] conn;
      for (int i = 0; i < n; i++) begin
         seq_a   = next_sample(seq_a);
         seq_b   = next_sample(seq_b);
         conn[0] = ($urandom_range(0, 99) < 88);
         conn[1] = ($urandom_range(0, 99) < 88);
         send_item(seq_a, seq_b, conn);
      end
   endtask

   function automatic logic [31:0] rand_gain();
      return int'($urandom_range(0, 98304)) - 49152;
   endfunction

   function automatic logic [31:0] rand_offset();
      return int'($urandom_range(0, 40960)) - 20480;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: extremes, warn threshold, connect combinations
      send_item(16'sd0, 16'sd0, 2'b11);
      send_item(16'sd32767, -16'sd32768, 2'b11);
      send_item(16'sd32767, -16'sd32768, 2'b11);
      send_item(-16'sd32768, 16'sd32767, 2'b00);
      send_item(-16'sd32768, 16'sd32767, 2'b01);
      send_item(16'sd20459, 16'sd20460, 2'b10);
      send_item(16'sd20460, 16'sd20459, 2'b11);
      send_item(-16'sd1, 16'sd1, 2'b11);
      send_item(16'sd1, -16'sd1, 2'b11);
      send_item(16'sd0, 16'sd0, 2'b00);
      run_random(250);

      // extreme steps, gains and offsets
      drain();
      set_channel(0, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 49152, 20480);
      set_channel(1, 1, 1, -49152, -20480);
      send_item(16'sd32767, 16'sd32767, 2'b11);
      send_item(-16'sd32768, -16'sd32768, 2'b11);
      send_item(-16'sd32767, 16'sd0, 2'b11);
      send_item(-16'sd32766, 16'sd0, 2'b11);
      send_item(-16'sd32768, 16'sd0, 2'b11);
      run_random(300);

      // random in-range setting, one long result stall midway
      drain();
      set_channel(0, $urandom_range(1, 1 << 26), $urandom_range(1, 1 << 26), rand_gain(),
                  rand_offset());
      set_channel(1, $urandom_range(1, 1 << 26), $urandom_range(1, 1 << 26), rand_gain(),
                  rand_offset());
      run_random(100);
      hold_request = 1'b1;
      run_random(200);

      // zero rise steps and channel a fall step, gain/offset out of nominal range
      drain();
      set_channel(0, 0, 0, 32'h0000_FFFF, 32'h0000_7FFF);
      set_channel(1, 0, $urandom_range(1, 1 << 20), 32'h0001_0000, 32'h0000_8000);
      run_random(250);

      // slow slewing, no idling on either side
      drain();
      set_channel(0, $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20), rand_gain(),
                  rand_offset());
      set_channel(1, $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20), rand_gain(),
                  rand_offset());
      quiet = 1'b1;
      run_random(350);
      quiet = 1'b0;

      // arbitrary bus values
      drain();
      set_channel(0, $urandom(), $urandom(), $urandom(), $urandom());
      set_channel(1, $urandom(), $urandom(), $urandom(), $urandom());
      run_random(300);

      // back to reset values
      drain();
      set_channel(0, 32'(RISE_STEP_RESET), 32'(FALL_STEP_RESET), 32'(GAIN_RESET),
                  32'(OFFSET_RESET));
      set_channel(1, 32'(RISE_STEP_RESET), 32'(FALL_STEP_RESET), 32'(GAIN_RESET),
                  32'(OFFSET_RESET));
      run_random(200);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
